[rtl/core/assert_macros.svh]
// Assertion helpers shared by the sequencer RTL.
// Every check is clocked on clk_i and is switched off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge.
`define OLEDSEQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// A condition in one cycle that must be followed by another in the next cycle.
`define OLEDSEQ_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

[rtl/core/oledseq_pkg.sv]
`default_nettype none

package oledseq_pkg;

  // Size of one full frame in bytes. The length field carries it modulo 2^11.
  localparam int unsigned FRAME_BYTES = 1024;
  localparam logic [10:0] FRAME_LEN = 11'(FRAME_BYTES % 2048);

  // Configuration register indexes.
  localparam logic [1:0] REG_POWER_WAIT  = 2'd0;
  localparam logic [1:0] REG_LINE_GAP    = 2'd1;
  localparam logic [1:0] REG_SETTLE      = 2'd2;
  localparam logic [1:0] REG_BUSY_TIMEOUT = 2'd3;

  // Register reset values in milliseconds.
  localparam logic [15:0] POWER_WAIT_RST   = 16'd1000;
  localparam logic [15:0] LINE_GAP_RST     = 16'd10;
  localparam logic [15:0] SETTLE_RST       = 16'd100;
  localparam logic [15:0] BUSY_TIMEOUT_RST = 16'd100;

  // Link status codes; any other value is treated as an error.
  localparam logic [1:0] BUSY_IDLE = 2'd0;
  localparam logic [1:0] BUSY_BUSY = 2'd1;

  // Transfer sources.
  localparam logic [2:0] SRC_INIT     = 3'd0;
  localparam logic [2:0] SRC_ZERO     = 3'd1;
  localparam logic [2:0] SRC_ON       = 3'd2;
  localparam logic [2:0] SRC_RANGE    = 3'd3;
  localparam logic [2:0] SRC_FRAME    = 3'd4;
  localparam logic [2:0] SRC_CONTRAST = 3'd5;

  // Transfer lengths in bytes.
  localparam logic [10:0] LEN_INIT     = 11'd28;
  localparam logic [10:0] LEN_ON       = 11'd1;
  localparam logic [10:0] LEN_RANGE    = 11'd6;
  localparam logic [10:0] LEN_CONTRAST = 11'd2;

  // Brightness levels and the contrast step per level.
  localparam logic [3:0] LEVEL_MIN     = 4'd1;
  localparam logic [3:0] LEVEL_MAX     = 4'd10;
  localparam logic [8:0] CONTRAST_STEP = 9'd23;

  // Mode codes reported with each result.
  localparam logic [3:0] MODE_START    = 4'd0;
  localparam logic [3:0] MODE_WAIT1    = 4'd1;
  localparam logic [3:0] MODE_WAIT2    = 4'd2;
  localparam logic [3:0] MODE_WAIT3    = 4'd3;
  localparam logic [3:0] MODE_INIT     = 4'd4;
  localparam logic [3:0] MODE_CLEAR    = 4'd5;
  localparam logic [3:0] MODE_ON       = 4'd6;
  localparam logic [3:0] MODE_SETTLE   = 4'd7;
  localparam logic [3:0] MODE_RANGE    = 4'd8;
  localparam logic [3:0] MODE_PIXELS   = 4'd9;
  localparam logic [3:0] MODE_CONTRAST = 4'd10;
  localparam logic [3:0] MODE_READY    = 4'd11;
  localparam logic [3:0] MODE_FAILED   = 4'd12;

  typedef enum logic [1:0] {
    ACT_POLL    = 2'd0,
    ACT_INIT    = 2'd1,
    ACT_PRESENT = 2'd2,
    ACT_BRIGHT  = 2'd3
  } action_e;

  typedef enum logic [12:0] {
    PH_START    = 13'b0_0000_0000_0001,
    PH_WAIT1    = 13'b0_0000_0000_0010,
    PH_WAIT2    = 13'b0_0000_0000_0100,
    PH_WAIT3    = 13'b0_0000_0000_1000,
    PH_INIT     = 13'b0_0000_0001_0000,
    PH_CLEAR    = 13'b0_0000_0010_0000,
    PH_ON       = 13'b0_0000_0100_0000,
    PH_SETTLE   = 13'b0_0000_1000_0000,
    PH_RANGE    = 13'b0_0001_0000_0000,
    PH_PIXELS   = 13'b0_0010_0000_0000,
    PH_CONTRAST = 13'b0_0100_0000_0000,
    PH_READY    = 13'b0_1000_0000_0000,
    PH_FAILED   = 13'b1_0000_0000_0000
  } phase_e;

  typedef struct packed {
    action_e     action;
    logic [31:0] now;
    logic [3:0]  level;
    logic        start_failed;
    logic [1:0]  busy_status;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic        lines_valid;
    logic        line_a;
    logic        line_b;
    logic        start_request;
    logic        start_is_data;
    logic [2:0]  start_source;
    logic [10:0] start_length;
    logic        cancel;
    logic [3:0]  mode;
    logic [7:0]  contrast;
  } out_item_t;

  typedef struct packed {
    logic [15:0] power_wait_ms;
    logic [15:0] line_gap_ms;
    logic [15:0] settle_ms;
    logic [15:0] busy_timeout_ms;
  } cfg_t;

  typedef struct packed {
    phase_e      phase;
    logic [31:0] since_time;
    logic        xfer_active;
    logic [7:0]  applied_contrast;
    logic [7:0]  pending_contrast;
  } seq_state_t;

  function automatic logic [3:0] mode_of(input phase_e ph);
    logic [3:0] m;
    case (ph)
      PH_START:    m = MODE_START;
      PH_WAIT1:    m = MODE_WAIT1;
      PH_WAIT2:    m = MODE_WAIT2;
      PH_WAIT3:    m = MODE_WAIT3;
      PH_INIT:     m = MODE_INIT;
      PH_CLEAR:    m = MODE_CLEAR;
      PH_ON:       m = MODE_ON;
      PH_SETTLE:   m = MODE_SETTLE;
      PH_RANGE:    m = MODE_RANGE;
      PH_PIXELS:   m = MODE_PIXELS;
      PH_CONTRAST: m = MODE_CONTRAST;
      PH_READY:    m = MODE_READY;
      PH_FAILED:   m = MODE_FAILED;
      default:     m = MODE_START;
    endcase
    return m;
  endfunction

  function automatic logic [7:0] contrast_of(input logic [3:0] level);
    logic [8:0] prod;
    prod = 9'(level) * CONTRAST_STEP;
    return prod[7:0];
  endfunction

endpackage

`default_nettype wire

[rtl/core/oledseq_cfg.sv]
`default_nettype none

module oledseq_cfg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_idx_i,
  input  wire logic [15:0]       cfg_data_i,
  output oledseq_pkg::cfg_t      cfg_o
);

  oledseq_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.power_wait_ms   <= oledseq_pkg::POWER_WAIT_RST;
      cfg_q.line_gap_ms     <= oledseq_pkg::LINE_GAP_RST;
      cfg_q.settle_ms       <= oledseq_pkg::SETTLE_RST;
      cfg_q.busy_timeout_ms <= oledseq_pkg::BUSY_TIMEOUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        oledseq_pkg::REG_POWER_WAIT:   cfg_q.power_wait_ms   <= cfg_data_i;
        oledseq_pkg::REG_LINE_GAP:     cfg_q.line_gap_ms     <= cfg_data_i;
        oledseq_pkg::REG_SETTLE:       cfg_q.settle_ms       <= cfg_data_i;
        oledseq_pkg::REG_BUSY_TIMEOUT: cfg_q.busy_timeout_ms <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[rtl/core/oledseq_step.sv]
`default_nettype none

module oledseq_step (
  input  wire oledseq_pkg::in_item_t   item_i,
  input  wire oledseq_pkg::seq_state_t state_i,
  input  wire oledseq_pkg::cfg_t       cfg_i,
  output oledseq_pkg::seq_state_t      state_o,
  output oledseq_pkg::out_item_t       result_o
);

  logic [31:0] elapsed;
  logic        xfer_en;
  logic        xfer_is_data;
  logic [2:0]  xfer_src;
  logic [10:0] xfer_len;
  logic        xfer_done;
  logic        fail;
  logic        busy_err;

  assign elapsed  = item_i.now - state_i.since_time;
  assign busy_err = (item_i.busy_status != oledseq_pkg::BUSY_IDLE) &&
                    (item_i.busy_status != oledseq_pkg::BUSY_BUSY);

  // Transfer that belongs to the current phase, if any.
  always_comb begin
    xfer_en      = 1'b1;
    xfer_is_data = 1'b0;
    xfer_src     = oledseq_pkg::SRC_INIT;
    xfer_len     = oledseq_pkg::LEN_INIT;
    case (state_i.phase)
      oledseq_pkg::PH_INIT: ;
      oledseq_pkg::PH_CLEAR: begin
        xfer_is_data = 1'b1;
        xfer_src     = oledseq_pkg::SRC_ZERO;
        xfer_len     = oledseq_pkg::FRAME_LEN;
      end
      oledseq_pkg::PH_ON: begin
        xfer_src = oledseq_pkg::SRC_ON;
        xfer_len = oledseq_pkg::LEN_ON;
      end
      oledseq_pkg::PH_RANGE: begin
        xfer_src = oledseq_pkg::SRC_RANGE;
        xfer_len = oledseq_pkg::LEN_RANGE;
      end
      oledseq_pkg::PH_PIXELS: begin
        xfer_is_data = 1'b1;
        xfer_src     = oledseq_pkg::SRC_FRAME;
        xfer_len     = oledseq_pkg::FRAME_LEN;
      end
      oledseq_pkg::PH_CONTRAST: begin
        xfer_src = oledseq_pkg::SRC_CONTRAST;
        xfer_len = oledseq_pkg::LEN_CONTRAST;
      end
      default: xfer_en = 1'b0;
    endcase
  end

  always_comb begin
    state_o   = state_i;
    result_o  = '0;
    xfer_done = 1'b0;
    fail      = 1'b0;
    case (item_i.action)
      oledseq_pkg::ACT_POLL: begin
        if (xfer_en) begin
          if (!state_i.xfer_active) begin
            result_o.start_request = 1'b1;
            result_o.start_is_data = xfer_is_data;
            result_o.start_source  = xfer_src;
            result_o.start_length  = xfer_len;
            if (item_i.start_failed) begin
              fail = 1'b1;
            end else begin
              state_o.since_time  = item_i.now;
              state_o.xfer_active = 1'b1;
            end
          end else if (busy_err) begin
            fail = 1'b1;
          end else if (item_i.busy_status == oledseq_pkg::BUSY_BUSY) begin
            if (elapsed >= {16'd0, cfg_i.busy_timeout_ms}) begin
              fail = 1'b1;
            end
          end else begin
            state_o.xfer_active = 1'b0;
            xfer_done           = 1'b1;
          end
        end

        case (state_i.phase)
          oledseq_pkg::PH_START: begin
            result_o.lines_valid = 1'b1;
            state_o.since_time   = item_i.now;
            state_o.phase        = oledseq_pkg::PH_WAIT1;
          end
          oledseq_pkg::PH_WAIT1: begin
            if (elapsed >= {16'd0, cfg_i.power_wait_ms}) begin
              result_o.lines_valid = 1'b1;
              result_o.line_b      = 1'b1;
              state_o.since_time   = item_i.now;
              state_o.phase        = oledseq_pkg::PH_WAIT2;
            end
          end
          oledseq_pkg::PH_WAIT2: begin
            if (elapsed >= {16'd0, cfg_i.line_gap_ms}) begin
              result_o.lines_valid = 1'b1;
              result_o.line_a      = 1'b1;
              result_o.line_b      = 1'b1;
              state_o.since_time   = item_i.now;
              state_o.phase        = oledseq_pkg::PH_WAIT3;
            end
          end
          oledseq_pkg::PH_WAIT3: begin
            if (elapsed >= {16'd0, cfg_i.settle_ms}) begin
              state_o.phase = oledseq_pkg::PH_INIT;
            end
          end
          oledseq_pkg::PH_INIT: begin
            if (xfer_done) state_o.phase = oledseq_pkg::PH_CLEAR;
          end
          oledseq_pkg::PH_CLEAR: begin
            if (xfer_done) state_o.phase = oledseq_pkg::PH_ON;
          end
          oledseq_pkg::PH_ON: begin
            if (xfer_done) begin
              state_o.phase      = oledseq_pkg::PH_SETTLE;
              state_o.since_time = item_i.now;
            end
          end
          oledseq_pkg::PH_SETTLE: begin
            if (elapsed >= {16'd0, cfg_i.settle_ms}) begin
              state_o.phase = oledseq_pkg::PH_READY;
            end
          end
          oledseq_pkg::PH_RANGE: begin
            if (xfer_done) state_o.phase = oledseq_pkg::PH_PIXELS;
          end
          oledseq_pkg::PH_PIXELS: begin
            if (xfer_done) state_o.phase = oledseq_pkg::PH_READY;
          end
          oledseq_pkg::PH_CONTRAST: begin
            if (xfer_done) begin
              state_o.applied_contrast = state_i.pending_contrast;
              state_o.phase            = oledseq_pkg::PH_READY;
            end
          end
          default: ;
        endcase

        if (fail) begin
          result_o.cancel     = 1'b1;
          state_o.xfer_active = 1'b0;
          state_o.phase       = oledseq_pkg::PH_FAILED;
        end
      end
      oledseq_pkg::ACT_INIT: begin
        state_o.phase            = oledseq_pkg::PH_START;
        state_o.since_time       = item_i.now;
        state_o.xfer_active      = 1'b0;
        state_o.applied_contrast = '0;
        state_o.pending_contrast = '0;
        result_o.accepted        = 1'b1;
      end
      oledseq_pkg::ACT_PRESENT: begin
        if (state_i.phase == oledseq_pkg::PH_READY) begin
          state_o.phase     = oledseq_pkg::PH_RANGE;
          result_o.accepted = 1'b1;
        end
      end
      oledseq_pkg::ACT_BRIGHT: begin
        if ((state_i.phase == oledseq_pkg::PH_READY) &&
            (item_i.level inside {[oledseq_pkg::LEVEL_MIN:oledseq_pkg::LEVEL_MAX]})) begin
          state_o.pending_contrast = oledseq_pkg::contrast_of(item_i.level);
          state_o.phase            = oledseq_pkg::PH_CONTRAST;
          result_o.accepted        = 1'b1;
        end
      end
      default: ;
    endcase

    result_o.mode     = oledseq_pkg::mode_of(state_o.phase);
    result_o.contrast = state_o.applied_contrast;
  end

endmodule

`default_nettype wire

[rtl/core/oled_power_up_and_refresh_sequencer_unit.sv]
`default_nettype none
`include "assert_macros.svh"

// OLED power-up and refresh sequencer. Each item is one timestamped event (poll
// tick, init, present frame or set brightness) and produces exactly one result
// item with the control line levels, an optional link transfer request, the
// cancel flag, the resulting mode and the applied contrast. The block takes one
// item per clock cycle while it is not stalled: an accepted item is held in the
// input register, and when the result register is free or drains, the step
// logic updates the sequencer state and loads the result register.
// The input side is stalled only while the input register holds an item and
// the result register is full and stalled. Configuration registers are written
// through a plain write port and should only change while no item is in flight.
module oled_power_up_and_refresh_sequencer_unit (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [1:0]             cfg_idx_i,
  input  wire logic [15:0]            cfg_data_i,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire oledseq_pkg::in_item_t  in_item_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output oledseq_pkg::out_item_t      out_item_o
);

  oledseq_pkg::cfg_t       cfg;
  oledseq_pkg::in_item_t   in_q;
  logic                    in_valid_q;
  oledseq_pkg::seq_state_t state_q;
  oledseq_pkg::seq_state_t state_d;
  oledseq_pkg::out_item_t  step_res;
  oledseq_pkg::out_item_t  out_q;
  logic                    out_valid_q;
  logic                    advance;
  logic                    in_take;
  logic                    xfer_phase;
  logic                    start_fire;
  logic                    start_kept;
  logic                    res_fail;
  logic                    res_wait;

  oledseq_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  oledseq_step u_step (
    .item_i   (in_q),
    .state_i  (state_q),
    .cfg_i    (cfg),
    .state_o  (state_d),
    .result_o (step_res)
  );

  // The held item is processed when the result register is free or drains now.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase            <= oledseq_pkg::PH_START;
      state_q.since_time       <= '0;
      state_q.xfer_active      <= 1'b0;
      state_q.applied_contrast <= '0;
      state_q.pending_contrast <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= step_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign xfer_phase = state_q.phase inside {oledseq_pkg::PH_INIT, oledseq_pkg::PH_CLEAR,
                                            oledseq_pkg::PH_ON, oledseq_pkg::PH_RANGE,
                                            oledseq_pkg::PH_PIXELS,
                                            oledseq_pkg::PH_CONTRAST};
  assign start_fire = advance && step_res.start_request;
  assign start_kept = state_q.xfer_active || (state_q.phase == oledseq_pkg::PH_FAILED);
  assign res_fail   = (out_q.mode == oledseq_pkg::MODE_FAILED);
  assign res_wait   = out_q.mode inside {oledseq_pkg::MODE_WAIT1, oledseq_pkg::MODE_WAIT2,
                                         oledseq_pkg::MODE_WAIT3};

  // A transfer can only be in flight in a phase that owns one.
  `OLEDSEQ_ASSERT(a_active_phase, state_q.xfer_active |-> xfer_phase, "transfer outside its phase")
  // A started transfer either stays in flight or has failed the sequence.
  `OLEDSEQ_ASSERT_NEXT(a_start_tracked, start_fire, start_kept, "started transfer not tracked")
  // A cancel always reports the failed mode.
  `OLEDSEQ_ASSERT(a_cancel_fails, (out_valid_q && out_q.cancel) |-> res_fail, "cancel, not failed")
  // Control lines are driven only on the way into the wait phases.
  `OLEDSEQ_ASSERT(a_lines_mode, (out_valid_q && out_q.lines_valid) |-> res_wait, "lines outside power-up")

endmodule

`default_nettype wire
